### hw/rtl/fpgs_pkg.sv
// Package for the fuzzy PID gain scheduler: register indexes, label codes,
// rule tables, pipeline stage types and the defuzzification mode.
// No dependencies.
package fpgs_pkg;

  // Register indexes of the configuration port
  localparam logic [2:0] RegErrorHigh = 3'd0;
  localparam logic [2:0] RegRateHigh  = 3'd1;
  localparam logic [2:0] RegKpLow     = 3'd2;
  localparam logic [2:0] RegKpHigh    = 3'd3;
  localparam logic [2:0] RegKiLow     = 3'd4;
  localparam logic [2:0] RegKiHigh    = 3'd5;
  localparam logic [2:0] RegKdLow     = 3'd6;
  localparam logic [2:0] RegKdHigh    = 3'd7;

  // Fuzzy labels, same numbering for inputs and outputs
  localparam logic [1:0] LabL = 2'd0;
  localparam logic [1:0] LabM = 2'd1;
  localparam logic [1:0] LabS = 2'd2;
  localparam logic [1:0] LabZ = 2'd3;

  // Defuzzification: 0 smallest of maxima, 1 largest of maxima, else mean
  localparam int unsigned DefuzzMode = 2;
  localparam int unsigned ModeSom    = 0;
  localparam int unsigned ModeLom    = 1;

  // Quotient bits of 768*d/span and the pipeline depth
  localparam int unsigned QuoW    = 10;
  localparam int unsigned RemW    = 25;
  localparam int unsigned NumStg  = 16;
  localparam int unsigned StgMu   = QuoW + 1;
  localparam int unsigned StgSel  = QuoW + 2;
  localparam int unsigned StgProd = QuoW + 3;
  localparam int unsigned StgRcp  = QuoW + 4;
  localparam int unsigned StgOut  = QuoW + 5;

  // ceil(2^19 / 3): exact divide by 3 for values below 2^19
  localparam logic [17:0] RecipThree = 18'h2AAAB;
  localparam int unsigned RecipShift = 19;

  // Rule tables [rate label][error label]
  localparam logic [1:0] KpRules [4][4] = '{
    '{2'd1, 2'd2, 2'd1, 2'd1}, '{2'd0, 2'd1, 2'd0, 2'd0},
    '{2'd0, 2'd1, 2'd0, 2'd0}, '{2'd0, 2'd1, 2'd0, 2'd3}};
  localparam logic [1:0] KiRules [4][4] = '{
    '{2'd3, 2'd2, 2'd1, 2'd0}, '{2'd3, 2'd2, 2'd0, 2'd0},
    '{2'd3, 2'd3, 2'd0, 2'd0}, '{2'd3, 2'd3, 2'd0, 2'd3}};
  localparam logic [1:0] KdRules [4][4] = '{
    '{2'd2, 2'd1, 2'd3, 2'd3}, '{2'd1, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd0, 2'd2, 2'd2}, '{2'd0, 2'd0, 2'd2, 2'd3}};

  // Divider stages: both inputs are divided side by side
  typedef struct packed {
    logic [RemW-1:0] rem_e;
    logic [QuoW-1:0] quo_e;
    logic [RemW-1:0] rem_r;
    logic [QuoW-1:0] quo_r;
    logic [1:0]      zone_e;
    logic [1:0]      zone_r;
    logic            empty_e;
    logic            empty_r;
  } div_stg_t;

  typedef struct packed {
    logic [8:0] mu_e1;
    logic [8:0] mu_e2;
    logic [8:0] mu_r1;
    logic [8:0] mu_r2;
    logic [1:0] zone_e;
    logic [1:0] zone_r;
  } mu_stg_t;

endpackage

### hw/rtl/fuzzy_pid_gain_scheduler.sv
// Fuzzy PID gain scheduler: fuzzify error and rate, pick the strongest rule
// pair, look up three rule tables and defuzzify into the gain ranges.
// Depends on fpgs_pkg.
//
//  channel  | signals                               | dir
//  ---------+---------------------------------------+-----
//  input    | in_valid_i, in_ready_o, error/rate_in | in
//  output   | out_valid_o, out_ready_i, gain_p/i/d  | out
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i       | in
//
// One item enters per cycle while the output does not stall; the pipeline is the ten
// compare-subtract stages of the membership divider plus six stages around it.
// Reset clears the stage valid bits and loads the register defaults.
// A stall at the output holds every stage; nothing is dropped or repeated.
module fuzzy_pid_gain_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] error_in_i,
  input  logic [15:0] rate_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] gain_p_o,
  output logic [15:0] gain_i_o,
  output logic [15:0] gain_d_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [14:0] error_high_q, rate_high_q;
  logic [15:0] lo_q [3];
  logic [15:0] hi_q [3];

  logic [fpgs_pkg::NumStg-1:0] vld_q;
  logic adv;

  fpgs_pkg::div_stg_t dq_q [fpgs_pkg::QuoW+1];
  fpgs_pkg::div_stg_t dq_d [fpgs_pkg::QuoW+1];
  fpgs_pkg::mu_stg_t  mu_q, mu_d;
  logic [8:0]  m_q, m_d;
  logic [1:0]  gl_q [3];
  logic [1:0]  gl_d [3];
  logic [25:0] pa_q [3];
  logic [25:0] pb_q [3];
  logic [25:0] pa_d [3];
  logic [25:0] pb_d [3];
  logic [15:0] qa_q [3];
  logic [15:0] qb_q [3];
  logic [15:0] qa_d [3];
  logic [15:0] qb_d [3];
  logic [15:0] g_q [3];
  logic [15:0] g_d [3];

  assign adv        = !vld_q[fpgs_pkg::StgOut] || out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[fpgs_pkg::StgOut];
  assign gain_p_o   = g_q[0];
  assign gain_i_o   = g_q[1];
  assign gain_d_o   = g_q[2];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_high_q <= 15'd256;
      rate_high_q  <= 15'd256;
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= 16'd0;
        hi_q[i] <= 16'd256;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fpgs_pkg::RegErrorHigh: error_high_q <= cfg_data_i[14:0];
        fpgs_pkg::RegRateHigh:  rate_high_q  <= cfg_data_i[14:0];
        fpgs_pkg::RegKpLow:     lo_q[0]      <= cfg_data_i;
        fpgs_pkg::RegKpHigh:    hi_q[0]      <= cfg_data_i;
        fpgs_pkg::RegKiLow:     lo_q[1]      <= cfg_data_i;
        fpgs_pkg::RegKiHigh:    hi_q[1]      <= cfg_data_i;
        fpgs_pkg::RegKdLow:     lo_q[2]      <= cfg_data_i;
        fpgs_pkg::RegKdHigh:    hi_q[2]      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  function automatic logic [14:0] mag_clamp(logic [15:0] raw, logic [14:0] high);
    logic [14:0] mag;
    if (!raw[15]) mag = raw[14:0];
    else if (raw == 16'h8000) mag = 15'h7FFF;
    else mag = 15'(-raw);
    return (mag > high) ? high : mag;
  endfunction

  function automatic logic [1:0] zone_of(logic [14:0] d, logic [14:0] span);
    logic [16:0] d3, s1, s2;
    d3 = {2'b00, d} + {1'b0, d, 1'b0};
    s1 = {2'b00, span};
    s2 = {1'b0, span, 1'b0};
    if (d3 < s1) return 2'd0;
    else if (d3 < s2) return 2'd1;
    else return 2'd2;
  endfunction

  function automatic logic [8:0] clamp_mu(logic signed [11:0] v);
    if (v < 0) return 9'd0;
    else if (v > 12'sd256) return 9'd256;
    else return v[8:0];
  endfunction

  // Stage 0: magnitudes, zones, dividend 768*d; then the divider with
  // one quotient bit per stage, most significant first
  always_comb begin
    logic [14:0] de, dr;
    logic [fpgs_pkg::RemW-1:0] ce, cr;
    de = mag_clamp(error_in_i, error_high_q);
    dr = mag_clamp(rate_in_i, rate_high_q);
    dq_d[0].rem_e   = (fpgs_pkg::RemW'(de) << 9) + (fpgs_pkg::RemW'(de) << 8);
    dq_d[0].rem_r   = (fpgs_pkg::RemW'(dr) << 9) + (fpgs_pkg::RemW'(dr) << 8);
    dq_d[0].quo_e   = '0;
    dq_d[0].quo_r   = '0;
    dq_d[0].zone_e  = zone_of(de, error_high_q);
    dq_d[0].zone_r  = zone_of(dr, rate_high_q);
    dq_d[0].empty_e = (error_high_q == 15'd0);
    dq_d[0].empty_r = (rate_high_q == 15'd0);
    for (int k = 1; k <= fpgs_pkg::QuoW; k++) begin
      dq_d[k] = dq_q[k-1];
      ce = fpgs_pkg::RemW'(error_high_q) << (fpgs_pkg::QuoW - k);
      cr = fpgs_pkg::RemW'(rate_high_q) << (fpgs_pkg::QuoW - k);
      if (dq_q[k-1].rem_e >= ce) begin
        dq_d[k].rem_e = dq_q[k-1].rem_e - ce;
        dq_d[k].quo_e[fpgs_pkg::QuoW-k] = 1'b1;
      end
      if (dq_q[k-1].rem_r >= cr) begin
        dq_d[k].rem_r = dq_q[k-1].rem_r - cr;
        dq_d[k].quo_r[fpgs_pkg::QuoW-k] = 1'b1;
      end
    end
  end

  // Memberships of the two labels of each zone
  always_comb begin
    fpgs_pkg::div_stg_t s;
    logic signed [11:0] be, br, ue, ur;
    s  = dq_q[fpgs_pkg::QuoW];
    be = $signed({2'b00, s.zone_e, 8'd0});
    br = $signed({2'b00, s.zone_r, 8'd0});
    ue = $signed({2'b00, s.quo_e});
    ur = $signed({2'b00, s.quo_r});
    mu_d.zone_e = s.zone_e;
    mu_d.zone_r = s.zone_r;
    mu_d.mu_e1  = s.empty_e ? 9'd0 : clamp_mu(be + 12'sd256 - ue);
    mu_d.mu_e2  = s.empty_e ? 9'd0 : clamp_mu(ue - be);
    mu_d.mu_r1  = s.empty_r ? 9'd0 : clamp_mu(br + 12'sd256 - ur);
    mu_d.mu_r2  = s.empty_r ? 9'd0 : clamp_mu(ur - br);
  end

  // Rule weights, winner (later pair on a tie), table lookup
  always_comb begin
    logic [8:0] w [4];
    logic [8:0] best;
    logic [1:0] sel, el, rl;
    w[0] = (mu_q.mu_e1 < mu_q.mu_r1) ? mu_q.mu_e1 : mu_q.mu_r1;
    w[1] = (mu_q.mu_e1 < mu_q.mu_r2) ? mu_q.mu_e1 : mu_q.mu_r2;
    w[2] = (mu_q.mu_e2 < mu_q.mu_r1) ? mu_q.mu_e2 : mu_q.mu_r1;
    w[3] = (mu_q.mu_e2 < mu_q.mu_r2) ? mu_q.mu_e2 : mu_q.mu_r2;
    best = w[0];
    sel  = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (w[k] >= best) begin
        best = w[k];
        sel  = 2'(k);
      end
    end
    el = sel[1] ? (2'd2 - mu_q.zone_e) : (2'd3 - mu_q.zone_e);
    rl = sel[0] ? (2'd2 - mu_q.zone_r) : (2'd3 - mu_q.zone_r);
    m_d     = best;
    gl_d[0] = fpgs_pkg::KpRules[rl][el];
    gl_d[1] = fpgs_pkg::KiRules[rl][el];
    gl_d[2] = fpgs_pkg::KdRules[rl][el];
  end

  // Peak numerators times the gain span
  always_comb begin
    logic [9:0] n1, n2, mx;
    logic [15:0] diff;
    mx = {1'b0, m_q};
    for (int g = 0; g < 3; g++) begin
      case (gl_q[g])
        fpgs_pkg::LabL: begin n1 = mx + 10'd512; n2 = n1; end
        fpgs_pkg::LabM: begin n1 = mx + 10'd256; n2 = 10'd768 - mx; end
        fpgs_pkg::LabS: begin n1 = mx; n2 = 10'd512 - mx; end
        default:        begin n1 = 10'd256 - mx; n2 = n1; end
      endcase
      diff    = hi_q[g] - lo_q[g];
      pa_d[g] = 26'(n1) * 26'(diff);
      pb_d[g] = 26'(n2) * 26'(diff);
    end
  end

  // Divide by 768: drop 8 bits, then multiply by the reciprocal of three
  always_comb begin
    logic [35:0] ta, tb;
    for (int g = 0; g < 3; g++) begin
      ta      = 36'(pa_q[g][25:8]) * 36'(fpgs_pkg::RecipThree);
      tb      = 36'(pb_q[g][25:8]) * 36'(fpgs_pkg::RecipThree);
      qa_d[g] = ta[fpgs_pkg::RecipShift +: 16];
      qb_d[g] = tb[fpgs_pkg::RecipShift +: 16];
    end
  end

  // Combine both peaks per mode; an empty gain range gives its low bound
  always_comb begin
    logic [15:0] r1, r2;
    logic [16:0] sum;
    for (int g = 0; g < 3; g++) begin
      r1  = lo_q[g] + qa_q[g];
      r2  = lo_q[g] + qb_q[g];
      sum = {1'b0, r1} + {1'b0, r2};
      if (hi_q[g] <= lo_q[g]) g_d[g] = lo_q[g];
      else if (fpgs_pkg::DefuzzMode == fpgs_pkg::ModeSom) g_d[g] = (r1 <= r2) ? r1 : r2;
      else if (fpgs_pkg::DefuzzMode == fpgs_pkg::ModeLom) g_d[g] = (r1 >= r2) ? r1 : r2;
      else g_d[g] = sum[16:1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[fpgs_pkg::NumStg-2:0], in_valid_i};
    end
  end

  // Payload advances with the valid bits; hold on stall
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= fpgs_pkg::QuoW; k++) dq_q[k] <= dq_d[k];
      mu_q  <= mu_d;
      m_q   <= m_d;
      for (int g = 0; g < 3; g++) begin
        gl_q[g] <= gl_d[g];
        pa_q[g] <= pa_d[g];
        pb_q[g] <= pb_d[g];
        qa_q[g] <= qa_d[g];
        qb_q[g] <= qb_d[g];
        g_q[g]  <= g_d[g];
      end
    end
  end

endmodule

### tb/tb_fuzzy_pid_gain_scheduler.sv
// Testbench for fuzzy_pid_gain_scheduler: drives error/rate items with random
// gaps and output stalls, predicts the three gains and checks every result.
// Depends on fpgs_pkg and the scheduler RTL.
`timescale 1ns / 100ps

module tb_fuzzy_pid_gain_scheduler;

  typedef struct {
    logic [15:0] p;
    logic [15:0] i;
    logic [15:0] d;
  } gains_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] error_in_i = '0;
  logic [15:0] rate_in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] gain_p_o, gain_i_o, gain_d_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  gains_t      pending_gains_q[$];
  logic [15:0] regs_shadow[8];
  int          err_cnt = 0;
  int          items_sent = 0;
  int          gains_checked = 0;
  int          cfg_writes = 0;
  bit          no_idle = 1'b0;

  // rule tables [rate label][error label]
  logic [1:0] kp_tab[4][4] = '{
    '{fpgs_pkg::LabM, fpgs_pkg::LabS, fpgs_pkg::LabM, fpgs_pkg::LabM},
    '{fpgs_pkg::LabL, fpgs_pkg::LabM, fpgs_pkg::LabL, fpgs_pkg::LabL},
    '{fpgs_pkg::LabL, fpgs_pkg::LabM, fpgs_pkg::LabL, fpgs_pkg::LabL},
    '{fpgs_pkg::LabL, fpgs_pkg::LabM, fpgs_pkg::LabL, fpgs_pkg::LabZ}};
  logic [1:0] ki_tab[4][4] = '{
    '{fpgs_pkg::LabZ, fpgs_pkg::LabS, fpgs_pkg::LabM, fpgs_pkg::LabL},
    '{fpgs_pkg::LabZ, fpgs_pkg::LabS, fpgs_pkg::LabL, fpgs_pkg::LabL},
    '{fpgs_pkg::LabZ, fpgs_pkg::LabZ, fpgs_pkg::LabL, fpgs_pkg::LabL},
    '{fpgs_pkg::LabZ, fpgs_pkg::LabZ, fpgs_pkg::LabL, fpgs_pkg::LabZ}};
  logic [1:0] kd_tab[4][4] = '{
    '{fpgs_pkg::LabS, fpgs_pkg::LabM, fpgs_pkg::LabZ, fpgs_pkg::LabZ},
    '{fpgs_pkg::LabM, fpgs_pkg::LabM, fpgs_pkg::LabS, fpgs_pkg::LabZ},
    '{fpgs_pkg::LabL, fpgs_pkg::LabL, fpgs_pkg::LabS, fpgs_pkg::LabS},
    '{fpgs_pkg::LabL, fpgs_pkg::LabL, fpgs_pkg::LabS, fpgs_pkg::LabZ}};
  logic [1:0] lower_lab[3] = '{fpgs_pkg::LabZ, fpgs_pkg::LabS, fpgs_pkg::LabM};
  logic [1:0] upper_lab[3] = '{fpgs_pkg::LabS, fpgs_pkg::LabM, fpgs_pkg::LabL};

  fuzzy_pid_gain_scheduler u_top (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int magnitude(logic [15:0] v);
    int m;
    m = v[15] ? 65536 - int'(v) : int'(v);
    return (m > 32767) ? 32767 : m;
  endfunction

  function automatic int clip_mu(int v);
    return (v < 0) ? 0 : (v > 256) ? 256 : v;
  endfunction

  function automatic void fuzzify(input int x, input int hi,
                                  output int zone, output int mu1, output int mu2);
    int u;
    if (x > hi) x = hi;
    if (3 * x < hi) zone = 0;
    else if (3 * x < 2 * hi) zone = 1;
    else zone = 2;
    if (hi == 0) begin
      mu1 = 0;
      mu2 = 0;
    end else begin
      u = (x * 768) / hi;
      mu1 = clip_mu(256 * (zone + 1) - u);
      mu2 = clip_mu(u - 256 * zone);
    end
  endfunction

  function automatic int scale_gain(int lo, int hi, int n);
    longint r;
    r = lo + (longint'(n) * (hi - lo)) / 768;
    return (r > hi) ? hi : int'(r);
  endfunction

  function automatic logic [15:0] defuzz(int lo, int hi, logic [1:0] lab, int m);
    int n1, n2, g1, g2;
    if (hi <= lo) return lo[15:0];
    case (lab)
      fpgs_pkg::LabL: begin n1 = m + 512; n2 = n1; end
      fpgs_pkg::LabM: begin n1 = m + 256; n2 = 768 - m; end
      fpgs_pkg::LabS: begin n1 = m; n2 = 512 - m; end
      default: begin n1 = 256 - m; n2 = n1; end
    endcase
    g1 = scale_gain(lo, hi, n1);
    g2 = scale_gain(lo, hi, n2);
    if (fpgs_pkg::DefuzzMode == fpgs_pkg::ModeSom) return 16'((g1 <= g2) ? g1 : g2);
    if (fpgs_pkg::DefuzzMode == fpgs_pkg::ModeLom) return 16'((g1 >= g2) ? g1 : g2);
    return 16'((g1 + g2) >> 1);
  endfunction

  function automatic gains_t schedule_gains(logic [15:0] err, logic [15:0] rate);
    int ez, rz, e1, e2, r1, r2, best, sel;
    int w[4];
    logic [1:0] el, rl;
    gains_t g;
    fuzzify(magnitude(err), regs_shadow[fpgs_pkg::RegErrorHigh], ez, e1, e2);
    fuzzify(magnitude(rate), regs_shadow[fpgs_pkg::RegRateHigh], rz, r1, r2);
    w[0] = (e1 < r1) ? e1 : r1;
    w[1] = (e1 < r2) ? e1 : r2;
    w[2] = (e2 < r1) ? e2 : r1;
    w[3] = (e2 < r2) ? e2 : r2;
    best = w[0];
    sel = 0;
    // later pair wins on a tie
    for (int k = 1; k < 4; k++) begin
      if (w[k] >= best) begin
        best = w[k];
        sel = k;
      end
    end
    el = sel[1] ? upper_lab[ez] : lower_lab[ez];
    rl = sel[0] ? upper_lab[rz] : lower_lab[rz];
    g.p = defuzz(regs_shadow[fpgs_pkg::RegKpLow], regs_shadow[fpgs_pkg::RegKpHigh],
                 kp_tab[rl][el], best);
    g.i = defuzz(regs_shadow[fpgs_pkg::RegKiLow], regs_shadow[fpgs_pkg::RegKiHigh],
                 ki_tab[rl][el], best);
    g.d = defuzz(regs_shadow[fpgs_pkg::RegKdLow], regs_shadow[fpgs_pkg::RegKdHigh],
                 kd_tab[rl][el], best);
    return g;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_item(logic [15:0] err, logic [15:0] rate);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    error_in_i <= err;
    rate_in_i  <= rate;
    do @(posedge clk_i); while (!in_ready_o);
    pending_gains_q.push_back(schedule_gains(err, rate));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (pending_gains_q.size() == 0);
    repeat (24) @(negedge clk_i);
  endtask

  // leaves the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    // the two universe registers are 15 bits wide
    regs_shadow[idx] = (idx == fpgs_pkg::RegErrorHigh || idx == fpgs_pkg::RegRateHigh) ?
                       {1'b0, val[14:0]} : val;
    cfg_writes++;
    @(negedge clk_i);
  endtask

  task automatic load_config(logic [15:0] eh, logic [15:0] rh, logic [15:0] kpl,
                             logic [15:0] kph, logic [15:0] kil, logic [15:0] kih,
                             logic [15:0] kdl, logic [15:0] kdh);
    drain();
    write_reg(fpgs_pkg::RegErrorHigh, eh);
    write_reg(fpgs_pkg::RegRateHigh, rh);
    write_reg(fpgs_pkg::RegKpLow, kpl);
    write_reg(fpgs_pkg::RegKpHigh, kph);
    write_reg(fpgs_pkg::RegKiLow, kil);
    write_reg(fpgs_pkg::RegKiHigh, kih);
    write_reg(fpgs_pkg::RegKdLow, kdl);
    write_reg(fpgs_pkg::RegKdHigh, kdh);
    cfg_we_i <= 1'b0;
  endtask

  // value near the universe of the given high, or anything at all
  function automatic logic [15:0] pick_input(int hi);
    int v;
    if ($urandom_range(0, 9) < 3) return 16'($urandom);
    v = $urandom_range(0, hi + hi / 4 + 1);
    if (v > 32767) v = 32767;
    return $urandom_range(0, 1) ? 16'(-v) : 16'(v);
  endfunction

  task automatic test_directed();
    logic [15:0] pts[12] = '{16'd0, 16'd85, 16'd86, 16'd128, 16'd170, 16'd171,
                             16'd256, 16'd300, 16'h7fff, 16'h8000, 16'hffff, 16'hff00};
    // two corners of the universe and the all-equal tie at the center
    for (int k = 0; k < 12; k++) send_item(pts[k], pts[11 - k]);
    send_item(16'd128, 16'd128);
    send_item(16'hff80, 16'd128);
    send_item(16'h8000, 16'h8000);
    send_item(16'h7fff, 16'd0);
    // empty universes: every weight zero, last pair wins
    load_config(16'h8000, 16'd0, 16'd0, 16'hffff, 16'h1234, 16'h1234,
                16'hffff, 16'd0);
    send_item(16'd0, 16'd0);
    send_item(16'd50, 16'h8000);
    send_item(16'hffff, 16'd7);
    load_config(16'h7fff, 16'hffff, 16'hffff, 16'd0, 16'd0, 16'hffff,
                16'd100, 16'd101);
    send_item(16'd10922, 16'd21845);
    send_item(16'h8000, 16'd16384);
    send_item(16'd32766, 16'd1);
  endtask

  task automatic test_random_phase(int n);
    int eh, rh;
    case ($urandom_range(0, 3))
      0: begin eh = 1; rh = 32767; end
      1: begin eh = 256; rh = 256; end
      default: begin eh = $urandom_range(1, 32767); rh = $urandom_range(1, 4096); end
    endcase
    load_config(16'(eh), 16'(rh), 16'($urandom), 16'($urandom), 16'($urandom_range(0, 999)),
                16'($urandom_range(1000, 65535)), 16'($urandom), 16'($urandom));
    repeat (n) send_item(pick_input(eh), pick_input(rh));
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    load_config(16'd256, 16'd512, 16'd0, 16'hffff, 16'd256, 16'd2560, 16'd512, 16'd0);
    repeat (120) send_item(pick_input(256), pick_input(512));
  endtask

  // check each result against the oldest prediction
  always @(posedge clk_i) begin
    gains_t exp_g;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_gains_q.size() == 0) begin
        $error("unexpected result: gain_p %h gain_i %h gain_d %h",
               gain_p_o, gain_i_o, gain_d_o);
        err_cnt++;
      end else begin
        exp_g = pending_gains_q.pop_front();
        gains_checked++;
        if (gain_p_o !== exp_g.p) begin
          $error("gain_p expected %h actual %h", exp_g.p, gain_p_o);
          err_cnt++;
        end
        if (gain_i_o !== exp_g.i) begin
          $error("gain_i expected %h actual %h", exp_g.i, gain_i_o);
          err_cnt++;
        end
        if (gain_d_o !== exp_g.d) begin
          $error("gain_d expected %h actual %h", exp_g.d, gain_d_o);
          err_cnt++;
        end
      end
    end
  end

  // output stalls in bursts
  initial begin
    forever begin
      @(negedge clk_i);
      if (rst_ni && !no_idle && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    regs_shadow = '{16'd256, 16'd256, 16'd0, 16'd256, 16'd0, 16'd256, 16'd0, 16'd256};
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    load_config(16'd256, 16'd256, 16'd0, 16'd256, 16'd0, 16'd256, 16'd0, 16'd256);
    repeat (150) send_item(pick_input(256), pick_input(256));
    repeat (5) test_random_phase(80);
    test_back_to_back();
    drain();
    $display("Covered %0d items and %0d results over %0d register writes,",
             items_sent, gains_checked, cfg_writes);
    $display("including empty universes, inverted bounds and full-range inputs.");
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
